/* hdl/bfns_pkg.sv */
// Shared types and constants for the bitmap find-next-set block.
package bfns_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_POS_W = 5;    // bit position inside one word
  localparam int unsigned BIT_IDX_W = 15;   // request bit index
  localparam int unsigned LEN_W     = 16;   // vector length and found position
  localparam int unsigned WIDX_W    = LEN_W - BIT_POS_W;  // word index of a length
  localparam int unsigned OP_W      = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 16'd32768;

  // register indexes on the configuration port
  localparam logic REG_VECTOR_LENGTH = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // word qualifiers for the scan unit
  typedef struct packed {
    logic                 is_first;
    logic [BIT_POS_W-1:0] start_bit;
    logic                 is_last;
    logic [BIT_POS_W-1:0] len_bit;
  } scan_ctl_t;

  typedef struct packed {
    logic                 hit;
    logic [BIT_POS_W-1:0] tz;
  } scan_res_t;

endpackage

/* hdl/bfns_mem.sv */
// Bitmap word store: one write port, one read port with registered read data.
module bfns_mem #(
  parameter int unsigned NUM_WORDS = 1024,
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  logic [31:0] mem [NUM_WORDS];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/bfns_scan.sv */
// Masks one bitmap word to the search window and counts its trailing zeros.
module bfns_scan (
  input  logic [31:0]          word_i,
  input  bfns_pkg::scan_ctl_t  ctl_i,
  output bfns_pkg::scan_res_t  res_o
);
  import bfns_pkg::*;

  logic [31:0]          mask_first;
  logic [31:0]          mask_last;
  logic [31:0]          w;
  logic [31:0]          s0, s1, s2, s3;
  logic [BIT_POS_W-1:0] cnt;

  always_comb begin
    mask_first = ctl_i.is_first ? (32'hFFFF_FFFF << ctl_i.start_bit) : 32'hFFFF_FFFF;
    // a length that ends inside the last word cuts off its upper bits
    if (ctl_i.is_last && (ctl_i.len_bit != '0)) begin
      mask_last = (32'h1 << ctl_i.len_bit) - 32'h1;
    end else begin
      mask_last = 32'hFFFF_FFFF;
    end
    w = word_i & mask_first & mask_last;

    cnt = '0;
    s0  = w;
    if (s0[15:0] == '0) begin
      cnt[4] = 1'b1;
      s0     = s0 >> 16;
    end
    s1 = s0;
    if (s1[7:0] == '0) begin
      cnt[3] = 1'b1;
      s1     = s1 >> 8;
    end
    s2 = s1;
    if (s2[3:0] == '0) begin
      cnt[2] = 1'b1;
      s2     = s2 >> 4;
    end
    s3 = s2;
    if (s3[1:0] == '0) begin
      cnt[1] = 1'b1;
      s3     = s3 >> 2;
    end
    if (s3[0] == 1'b0) begin
      cnt[0] = 1'b1;
    end

    res_o.hit = (w != '0);
    res_o.tz  = cnt;
  end

endmodule

/* hdl/bitmap_find_next_set_core.sv */
// Top level: bitmap store with set, clear, read and find-next-set requests.
//
// Requests arrive on the s_axis channel: tuser carries the operation, tdata
// the bit index. Each request gives exactly one result transfer on m_axis:
// tdata holds bit_value (read only) and found_position (find only).
// vector_length is written over the APB port at address 0 while idle.
//
// Timing: the word is read from the store in the cycle a request is taken
// and registered in the store's read register; the result is loaded into the
// output register once the receiver has room. A find reads one word after
// another from its start word until a hit or the last word (at least one);
// the single read port of the store gives one word per cycle.
//
// After reset the store is zeroed by a pass over all NUM_WORDS words, one word a
// cycle; s_axis_tready stays low until it ends. The result sits in an output
// register: a stalled receiver holds it, and the block still takes the next
// request, finishing it up to the point where its result is loaded.
module bitmap_find_next_set_core #(
  parameter int unsigned NUM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] bit_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] bit_value, [16:1] found_position
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfns_pkg::*;

  localparam int unsigned AW  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned CAP = NUM_WORDS * WORD_BITS;

  state_e state_q, state_d;

  logic [LEN_W-1:0]     vlen_q;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  op_e                  op_q, op_d;
  logic [BIT_IDX_W-1:0] idx_q, idx_d;
  logic [WIDX_W-1:0]    word_q, word_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [WIDX_W-1:0]    last_q, last_d;
  logic                 start_ge_q, start_ge_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_bit_q, out_bit_d;
  logic [LEN_W-1:0]     out_pos_q, out_pos_d;

  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     len_m1;
  logic                 in_fire;
  logic                 slot_free;
  logic                 in_store;
  logic                 done;
  logic [31:0]          bitmask;
  logic [31:0]          rd_word;
  logic [31:0]          rd_addr_wide;
  logic [31:0]          wr_addr_wide;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [31:0]          wr_data;
  logic [WIDX_W-1:0]    start_word;
  scan_ctl_t            scan_ctl;
  scan_res_t            scan_res;

  // ---------------- configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VECTOR_LENGTH)) begin
      vlen_q <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_VECTOR_LENGTH) ? 32'(vlen_q) : 32'd0;

  // ---------------- store and scan unit
  bfns_mem #(
    .NUM_WORDS (NUM_WORDS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  assign start_word         = WIDX_W'(idx_q[BIT_IDX_W-1:BIT_POS_W]);
  assign scan_ctl.is_first  = (word_q == start_word);
  assign scan_ctl.start_bit = idx_q[BIT_POS_W-1:0];
  assign scan_ctl.is_last   = (word_q == last_q);
  assign scan_ctl.len_bit   = len_q[BIT_POS_W-1:0];

  bfns_scan u_scan (
    .word_i (rd_word),
    .ctl_i  (scan_ctl),
    .res_o  (scan_res)
  );

  // ---------------- control
  assign len_eff   = (32'(vlen_q) > CAP) ? LEN_W'(CAP) : vlen_q;
  assign len_m1    = len_eff - LEN_W'(1);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign in_store  = (32'(word_q) < NUM_WORDS);
  assign bitmask   = 32'h1 << idx_q[BIT_POS_W-1:0];
  assign done      = (op_q != OP_FIND) || start_ge_q || scan_res.hit || scan_ctl.is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    word_q     <= word_d;
    len_q      <= len_d;
    last_q     <= last_d;
    start_ge_q <= start_ge_d;
    out_bit_q  <= out_bit_d;
    out_pos_q  <= out_pos_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    op_d         = op_q;
    idx_d        = idx_q;
    word_d       = word_q;
    len_d        = len_q;
    last_d       = last_q;
    start_ge_d   = start_ge_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_bit_d    = out_bit_q;
    out_pos_d    = out_pos_q;
    s_axis_tready = 1'b0;
    rd_en        = 1'b0;
    rd_addr_wide = 32'(word_q);
    wr_en        = 1'b0;
    wr_addr_wide = 32'(word_q);
    wr_data      = rd_word;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr_wide = 32'(clr_cnt_q);
        wr_data      = '0;
        clr_cnt_d    = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(NUM_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          op_d         = op_e'(s_axis_tuser);
          idx_d        = s_axis_tdata[BIT_IDX_W-1:0];
          word_d       = WIDX_W'(s_axis_tdata[BIT_IDX_W-1:BIT_POS_W]);
          len_d        = len_eff;
          last_d       = len_m1[LEN_W-1:BIT_POS_W];
          start_ge_d   = (LEN_W'(s_axis_tdata[BIT_IDX_W-1:0]) >= len_eff);
          rd_en        = 1'b1;
          rd_addr_wide = 32'(s_axis_tdata[BIT_IDX_W-1:BIT_POS_W]);
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_bit_d   = 1'b0;
            out_pos_d   = '0;
            unique case (op_q)
              OP_SET: begin
                wr_en   = in_store;
                wr_data = rd_word | bitmask;
              end
              OP_CLEAR: begin
                wr_en   = in_store;
                wr_data = rd_word & ~bitmask;
              end
              OP_READ: begin
                out_bit_d = in_store && ((rd_word & bitmask) != '0);
              end
              OP_FIND: begin
                if (!start_ge_q && scan_res.hit) begin
                  out_pos_d = {word_q, scan_res.tz};
                end else begin
                  out_pos_d = len_q;
                end
              end
              default: ;
            endcase
            state_d = ST_IDLE;
          end
        end else begin
          // no hit yet: fetch the next word
          word_d       = word_q + WIDX_W'(1);
          rd_en        = 1'b1;
          rd_addr_wide = 32'(word_q + WIDX_W'(1));
        end
      end
      default: state_d = ST_IDLE;
    endcase

    rd_addr = rd_addr_wide[AW-1:0];
    wr_addr = wr_addr_wide[AW-1:0];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_pos_q, out_bit_q};

endmodule

/* hdl/bfns_checker.sv */
// Port-level checks for the bitmap find-next-set block, bound to the top level.
module bfns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // only one of the two result fields can be nonzero
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[16:1] != 16'd0)))
    else $error("bit_value and found_position both set");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0))
    else $error("nonzero padding in result");

  // store is being zeroed right after reset
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("request taken during clearing pass");

endmodule

bind bitmap_find_next_set_core bfns_checker u_bfns_checker (.*);

/* verif/bitmap_find_next_set_core_test.sv */
// Self-checking stream testbench for the bitmap set/clear/read/find-next-set block.
module bitmap_find_next_set_core_test;
  import bfns_pkg::*;

  localparam int unsigned STORE_WORDS    = 1024;
  localparam int unsigned STORE_BITS     = STORE_WORDS * WORD_BITS;
  localparam int unsigned NUM_PHASES     = 16;
  localparam int unsigned ITEMS_PER_PHASE = 96;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned DRAIN_PHASE    = 6;
  localparam int unsigned UNUSED_PHASE   = 3;

  localparam logic [2:0] LENGTH_ADDR = {REG_VECTOR_LENGTH, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = {~REG_VECTOR_LENGTH, 2'b00};

  // lengths past the store (40000, 65535) are clipped to the store size
  localparam logic [15:0] PHASE_LENGTHS [NUM_PHASES] = '{
    16'd32768, 16'd0, 16'd1, 16'd31, 16'd32, 16'd33, 16'd100, 16'd1000,
    16'd65535, 16'd40000, 16'd63, 16'd64, 16'd2048, 16'd500, 16'd4097, 16'd32768
  };

  typedef struct packed {
    logic        bit_value;
    logic [15:0] found_pos;
  } bit_result_t;

  class bitmap_checker;
    logic [31:0]   bitmap_q [STORE_WORDS];
    logic [15:0]   vector_len;
    bit_result_t   pending_q [$];
    int unsigned   error_count;

    function new();
      foreach (bitmap_q[i]) bitmap_q[i] = '0;
      vector_len  = LEN_RESET;
      error_count = 0;
    endfunction

    function void write_length(logic [15:0] value);
      vector_len = value;
    endfunction

    function int unsigned pending_results();
      return pending_q.size();
    endfunction

    function logic [15:0] next_set_from(logic [14:0] start);
      int unsigned limit;
      int unsigned last_word;
      int unsigned w_idx;
      logic [31:0] w;
      limit = (vector_len > STORE_BITS) ? STORE_BITS : vector_len;
      if (start >= limit) return limit[15:0];
      last_word = (limit - 1) >> 5;
      for (w_idx = start >> 5; w_idx <= last_word; w_idx++) begin
        w = bitmap_q[w_idx];
        if (w_idx == (start >> 5)) w &= 32'hFFFF_FFFF << start[4:0];
        // bits of the last word at or past the length do not count
        if (w_idx == last_word && limit[4:0] != 5'd0) w &= (32'd1 << limit[4:0]) - 32'd1;
        for (int b = 0; b < 32; b++) begin
          if (w[b]) return 16'(w_idx * 32 + b);
        end
      end
      return limit[15:0];
    endfunction

    function void note_request(op_e op, logic [14:0] idx);
      bit_result_t r;
      r = '0;
      case (op)
        OP_SET:   bitmap_q[idx[14:5]][idx[4:0]] = 1'b1;
        OP_CLEAR: bitmap_q[idx[14:5]][idx[4:0]] = 1'b0;
        OP_READ:  r.bit_value = bitmap_q[idx[14:5]][idx[4:0]];
        OP_FIND:  r.found_pos = next_set_from(idx);
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (error_count < 100) $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
    endtask

    task check_result(logic [23:0] data);
      bit_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", data));
        return;
      end
      want = pending_q.pop_front();
      if (data[0] !== want.bit_value)
        report_mismatch($sformatf("bit_value %b, want %b", data[0], want.bit_value));
      if (data[16:1] !== want.found_pos)
        report_mismatch($sformatf("found_position %0d, want %0d", data[16:1], want.found_pos));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [14:0] bit_index
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [0] bit_value, [16:1] found_position
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bitmap_checker results;
  int unsigned   tx_idle_pct;
  int unsigned   rx_stall_pct;
  logic          rx_hold_arm;
  bit            rx_hold_done;
  int unsigned   quiet_cycles;

  bitmap_find_next_set_core #(.NUM_WORDS(STORE_WORDS)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // transfer monitor: requests update the predicted bitmap, results are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) results.note_request(op_e'(s_axis_tuser), s_axis_tdata[14:0]);
      if (m_axis_tvalid && m_axis_tready) results.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("bitmap_find_next_set_core_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver, with one long hold-off when armed
  initial begin
    m_axis_tready = 1'b0;
    rx_hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_arm && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_request(op_e op, logic [14:0] idx);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, idx};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results.pending_results() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write, then read the length register back
  task automatic write_config(logic [2:0] addr, logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, addr, value, rd);
    if (addr == LENGTH_ADDR) results.write_length(value[15:0]);
    apb_access(1'b0, LENGTH_ADDR, 32'd0, rd);
    if (rd[15:0] !== results.vector_len)
      results.report_mismatch($sformatf("vector_length reads %0d, want %0d",
                                        rd[15:0], results.vector_len));
  endtask

  task automatic run_directed();
    send_request(OP_READ,  15'd0);
    send_request(OP_FIND,  15'd0);       // empty store: nothing found
    send_request(OP_FIND,  15'd32767);
    send_request(OP_SET,   15'd0);
    send_request(OP_SET,   15'd31);
    send_request(OP_SET,   15'd32);
    send_request(OP_SET,   15'd32767);
    send_request(OP_SET,   15'd12345);
    send_request(OP_SET,   15'd21845);   // alternating index bits
    send_request(OP_SET,   15'd10922);
    send_request(OP_READ,  15'd0);
    send_request(OP_READ,  15'd32767);
    send_request(OP_READ,  15'd1);
    send_request(OP_FIND,  15'd0);
    send_request(OP_FIND,  15'd1);
    send_request(OP_FIND,  15'd32);
    send_request(OP_FIND,  15'd33);
    send_request(OP_CLEAR, 15'd10922);
    send_request(OP_FIND,  15'd12346);
    send_request(OP_FIND,  15'd32767);
    send_request(OP_CLEAR, 15'd0);
    send_request(OP_READ,  15'd0);
    send_request(OP_FIND,  15'd0);
    send_request(OP_READ,  15'd10922);
  endtask

  initial begin
    int unsigned eff_len;
    int unsigned hot;
    int unsigned r;
    logic [14:0] idx;
    op_e         op;

    results       = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SET;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_hold_arm   = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    quiet_cycles  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 79; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 79; end
        default: begin tx_idle_pct = 38; rx_stall_pct <= 38; end
      endcase
      if (ph == UNUSED_PHASE) write_config(UNUSED_ADDR, 32'd7);
      write_config(LENGTH_ADDR, {16'($urandom), PHASE_LENGTHS[ph]});
      if (ph == PRESSURE_PHASE) rx_hold_arm <= 1'b1;

      eff_len = (PHASE_LENGTHS[ph] > STORE_BITS) ? STORE_BITS : PHASE_LENGTHS[ph];
      hot     = (eff_len + 40 > 32767) ? 32767 : eff_len + 40;
      send_request(OP_FIND, 15'd0);
      send_request(OP_FIND, 15'((eff_len > 32767) ? 32767 : eff_len));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2) drain_results();
        r  = $urandom_range(99);
        op = (r < 35) ? OP_SET : (r < 50) ? OP_CLEAR : (r < 70) ? OP_READ : OP_FIND;
        // mostly at or below the length plus 40, sometimes anywhere in the store
        idx = ($urandom_range(99) < 80) ? 15'($urandom_range(hot)) : 15'($urandom_range(32767));
        send_request(op, idx);
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (results.error_count == 0) begin
      $display("bitmap_find_next_set_core_test: clean");
    end else begin
      $display("bitmap_find_next_set_core_test: errors");
    end
    $finish;
  end

endmodule
